// ===== design/erm_pkg.sv =====
// shared types, constants and helper functions for the euler rotation matrix block
// no dependencies

package erm_pkg;

  localparam int unsigned CORDIC_STEPS_DEF   = 16;
  localparam int unsigned ELEM_FRAC_BITS_DEF = 16;

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_ROTATE = 1'b1;

  localparam logic [1:0] STAGE_X = 2'd0;
  localparam logic [1:0] STAGE_Y = 2'd1;
  localparam logic [1:0] STAGE_Z = 2'd2;

  localparam logic signed [35:0] ANG_PI      = 36'sd3373259426;
  localparam logic signed [35:0] ANG_HALF_PI = 36'sd1686629713;
  localparam logic signed [35:0] ANG_TWO_PI  = 36'sd6746518852;
  localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;

  typedef struct packed {
    logic               action;
    logic [3:0]         elem_index;
    logic signed [31:0] elem_value;
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
  } in_t;

  typedef struct packed {
    logic [3:0]         out_index;
    logic signed [31:0] out_value;
    logic               last;
  } out_t;

  // atan(2^-i) in q30, truncated
  function automatic logic signed [35:0] atan_q30(input logic [4:0] idx);
    logic signed [35:0] r;
    unique case (idx)
      5'd0:  r = 36'sd843314856;
      5'd1:  r = 36'sd497837829;
      5'd2:  r = 36'sd263043836;
      5'd3:  r = 36'sd133525158;
      5'd4:  r = 36'sd67021686;
      5'd5:  r = 36'sd33543515;
      5'd6:  r = 36'sd16775850;
      5'd7:  r = 36'sd8388437;
      5'd8:  r = 36'sd4194282;
      5'd9:  r = 36'sd2097149;
      5'd10: r = 36'sd1048575;
      5'd11: r = 36'sd524287;
      5'd12: r = 36'sd262143;
      5'd13: r = 36'sd131071;
      5'd14: r = 36'sd65535;
      5'd15: r = 36'sd32767;
      5'd16: r = 36'sd16383;
      5'd17: r = 36'sd8191;
      5'd18: r = 36'sd4095;
      5'd19: r = 36'sd2047;
      5'd20: r = 36'sd1023;
      5'd21: r = 36'sd511;
      5'd22: r = 36'sd255;
      5'd23: r = 36'sd127;
      default: r = '0;
    endcase
    return r;
  endfunction

  // element (row, col) of the rotation matrix for one axis
  function automatic logic signed [31:0] rot_elem(
    input logic [1:0]         stage,
    input logic [1:0]         row,
    input logic [1:0]         col,
    input logic signed [31:0] s,
    input logic signed [31:0] c,
    input logic signed [31:0] one
  );
    logic signed [31:0] r;
    r = (row == col) ? one : '0;
    unique case (stage)
      STAGE_X: begin
        if (row == 2'd1 && col == 2'd1) r = c;
        if (row == 2'd1 && col == 2'd2) r = -s;
        if (row == 2'd2 && col == 2'd1) r = s;
        if (row == 2'd2 && col == 2'd2) r = c;
      end
      STAGE_Y: begin
        if (row == 2'd0 && col == 2'd0) r = c;
        if (row == 2'd0 && col == 2'd2) r = s;
        if (row == 2'd2 && col == 2'd0) r = -s;
        if (row == 2'd2 && col == 2'd2) r = c;
      end
      STAGE_Z: begin
        if (row == 2'd0 && col == 2'd0) r = c;
        if (row == 2'd0 && col == 2'd1) r = -s;
        if (row == 2'd1 && col == 2'd0) r = s;
        if (row == 2'd1 && col == 2'd1) r = c;
      end
      default: r = r;
    endcase
    return r;
  endfunction

endpackage

// ===== design/erm_cordic.sv =====
// iterative cordic sine/cosine of one q3.12 angle, one micro-rotation per cycle
// depends on erm_pkg

module erm_cordic #(
  parameter int unsigned CORDIC_STEPS   = erm_pkg::CORDIC_STEPS_DEF,
  parameter int unsigned ELEM_FRAC_BITS = erm_pkg::ELEM_FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [15:0] angle_i,
  output logic               done_o,
  output logic signed [31:0] sin_o,
  output logic signed [31:0] cos_o
);
  import erm_pkg::*;

  localparam int unsigned IW = $clog2(CORDIC_STEPS);
  localparam int unsigned SH = 30 - ELEM_FRAC_BITS;
  localparam logic signed [34:0] RND = 35'sd1 <<< (SH - 1);
  localparam logic signed [31:0] ONE = 32'sd1 <<< ELEM_FRAC_BITS;

  typedef enum logic [2:0] {C_IDLE, C_WRAP, C_FOLD, C_ITER, C_OUT} cstate_e;

  cstate_e            state_q;
  logic signed [35:0] a_q;
  logic signed [33:0] x_q, y_q;
  logic               neg_q;
  logic [IW-1:0]      i_q;
  logic               done_q;
  logic signed [31:0] sin_q, cos_q;

  logic signed [33:0] xs, ys;
  logic signed [35:0] at;
  logic signed [34:0] xf, yf;

  assign xs = x_q >>> i_q;
  assign ys = y_q >>> i_q;
  assign at = atan_q30(5'(i_q));
  assign xf = (neg_q ? -35'(x_q) : 35'(x_q)) + RND;
  assign yf = (neg_q ? -35'(y_q) : 35'(y_q)) + RND;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      done_q  <= 1'b0;
      a_q     <= '0;
      x_q     <= '0;
      y_q     <= '0;
      neg_q   <= 1'b0;
      i_q     <= '0;
      sin_q   <= '0;
      cos_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        C_IDLE: begin
          if (start_i) begin
            if (angle_i == 16'sd0) begin
              sin_q  <= '0;
              cos_q  <= ONE;
              done_q <= 1'b1;
            end else begin
              a_q     <= {{2{angle_i[15]}}, angle_i, 18'b0};
              state_q <= C_WRAP;
            end
          end
        end
        C_WRAP: begin
          if (a_q > ANG_PI) begin
            a_q <= a_q - ANG_TWO_PI;
          end else if (a_q < -ANG_PI) begin
            a_q <= a_q + ANG_TWO_PI;
          end else begin
            state_q <= C_FOLD;
          end
        end
        C_FOLD: begin
          if (a_q > ANG_HALF_PI) begin
            a_q   <= a_q - ANG_PI;
            neg_q <= 1'b1;
          end else if (a_q < -ANG_HALF_PI) begin
            a_q   <= a_q + ANG_PI;
            neg_q <= 1'b1;
          end else begin
            neg_q <= 1'b0;
          end
          x_q     <= GAIN_Q30;
          y_q     <= '0;
          i_q     <= '0;
          state_q <= C_ITER;
        end
        C_ITER: begin
          if (a_q >= 0) begin
            x_q <= x_q - ys;
            y_q <= y_q + xs;
            a_q <= a_q - at;
          end else begin
            x_q <= x_q + ys;
            y_q <= y_q - xs;
            a_q <= a_q + at;
          end
          if (i_q == IW'(CORDIC_STEPS - 1)) begin
            state_q <= C_OUT;
          end else begin
            i_q <= i_q + 1'b1;
          end
        end
        C_OUT: begin
          cos_q   <= 32'(xf >>> SH);
          sin_q   <= 32'(yf >>> SH);
          done_q  <= 1'b1;
          state_q <= C_IDLE;
        end
        default: state_q <= C_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign sin_o  = sin_q;
  assign cos_o  = cos_q;

endmodule

// ===== design/euler_rotation_matrix.sv =====
// euler rotation matrix: base*rx*ry*rz over one shared multiplier, with cordic sin/cos
// depends on erm_pkg and erm_cordic
//
// usage: one input channel (in_valid_i, in_stall_o, in_data_i) and one output
// channel (out_valid_o, out_stall_i, out_data_o); a transaction moves when
// valid is high and stall is low at a rising clock edge.
// a load transaction writes one base element and gives no output.
// a rotate transaction runs cordic for the x, y and z angles in turn (a zero
// angle skips the iterations; otherwise the angle is wrapped by 2*pi, folded
// and rotated over CORDIC_STEPS micro-rotations), then three matrix products
// on one 32x32 multiplier, each product followed by a copy into the working
// matrix, then emits 16 elements in row-major order, one per cycle while the
// receiver does not stall, last set on the sixteenth.
// in_stall_o is high from the accepted rotate until the last element is taken.
// a stalled output holds its element. reset loads the identity base matrix
// and leaves both channels idle.

module euler_rotation_matrix #(
  parameter int unsigned CORDIC_STEPS   = erm_pkg::CORDIC_STEPS_DEF,
  parameter int unsigned ELEM_FRAC_BITS = erm_pkg::ELEM_FRAC_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  erm_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output erm_pkg::out_t out_data_o
);
  import erm_pkg::*;

  localparam logic signed [31:0] ONE = 32'sd1 <<< ELEM_FRAC_BITS;
  localparam logic signed [67:0] RND = 68'sd1 <<< (ELEM_FRAC_BITS - 1);
  localparam logic signed [67:0] SMAX = 68'sd2147483647;
  localparam logic signed [67:0] SMIN = -68'sd2147483648;

  typedef enum logic [2:0] {S_IDLE, S_CSTART, S_CWAIT, S_MAC, S_COPY, S_OUT} state_e;

  state_e             state_q;
  logic signed [31:0] base_q [16];
  logic signed [31:0] work_q [16];
  logic signed [31:0] res_q  [16];
  logic signed [15:0] ang_q  [3];
  logic signed [31:0] sin_q  [3];
  logic signed [31:0] cos_q  [3];
  logic [1:0]         ax_q;
  logic [3:0]         e_q;
  logic [2:0]         j_q;
  logic signed [63:0] prod_q;
  logic signed [65:0] acc_q;
  logic               out_valid_q;
  out_t               out_q;

  logic               cs_start;
  logic               cs_done;
  logic signed [31:0] cs_sin, cs_cos;

  logic [3:0]         a_idx;
  logic signed [31:0] a_sel, b_sel;
  logic signed [63:0] prod_d;
  logic signed [67:0] sum;
  logic signed [67:0] shifted;
  logic signed [31:0] sat_val;

  erm_cordic #(
    .CORDIC_STEPS  (CORDIC_STEPS),
    .ELEM_FRAC_BITS(ELEM_FRAC_BITS)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cs_start),
    .angle_i(ang_q[ax_q]),
    .done_o (cs_done),
    .sin_o  (cs_sin),
    .cos_o  (cs_cos)
  );

  assign cs_start = (state_q == S_CSTART);

  assign a_idx  = {e_q[3:2], j_q[1:0]};
  assign a_sel  = (ax_q == STAGE_X) ? base_q[a_idx] : work_q[a_idx];
  assign b_sel  = rot_elem(ax_q, j_q[1:0], e_q[1:0], sin_q[ax_q], cos_q[ax_q], ONE);
  assign prod_d = a_sel * b_sel;

  assign sum     = 68'(acc_q) + 68'(prod_q) + RND;
  assign shifted = sum >>> ELEM_FRAC_BITS;

  always_comb begin
    priority if (shifted > SMAX) begin
      sat_val = 32'sh7fffffff;
    end else if (shifted < SMIN) begin
      sat_val = 32'sh80000000;
    end else begin
      sat_val = shifted[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ax_q        <= '0;
      e_q         <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        base_q[i] <= ((i % 5) == 0) ? ONE : '0;
      end
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            if (in_data_i.action == ACT_LOAD) begin
              base_q[in_data_i.elem_index] <= in_data_i.elem_value;
            end else begin
              ang_q[0] <= in_data_i.angle_x;
              ang_q[1] <= in_data_i.angle_y;
              ang_q[2] <= in_data_i.angle_z;
              ax_q     <= STAGE_X;
              state_q  <= S_CSTART;
            end
          end
        end
        S_CSTART: begin
          state_q <= S_CWAIT;
        end
        S_CWAIT: begin
          if (cs_done) begin
            sin_q[ax_q] <= cs_sin;
            cos_q[ax_q] <= cs_cos;
            if (ax_q == STAGE_Z) begin
              ax_q    <= STAGE_X;
              e_q     <= '0;
              j_q     <= '0;
              state_q <= S_MAC;
            end else begin
              ax_q    <= ax_q + 1'b1;
              state_q <= S_CSTART;
            end
          end
        end
        S_MAC: begin
          if (j_q == 3'd4) begin
            res_q[e_q] <= sat_val;
            j_q        <= '0;
            if (e_q == 4'd15) begin
              e_q     <= '0;
              state_q <= S_COPY;
            end else begin
              e_q <= e_q + 1'b1;
            end
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
        S_COPY: begin
          for (int i = 0; i < 16; i++) begin
            work_q[i] <= res_q[i];
          end
          if (ax_q == STAGE_Z) begin
            e_q         <= '0;
            out_valid_q <= 1'b1;
            state_q     <= S_OUT;
          end else begin
            ax_q    <= ax_q + 1'b1;
            state_q <= S_MAC;
          end
        end
        S_OUT: begin
          if (out_valid_q && !out_stall_i) begin
            if (e_q == 4'd15) begin
              out_valid_q <= 1'b0;
              state_q     <= S_IDLE;
            end else begin
              e_q <= e_q + 1'b1;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // multiply-accumulate datapath and output payload
  always_ff @(posedge clk_i) begin
    if (state_q == S_MAC) begin
      prod_q <= prod_d;
      acc_q  <= (j_q == 3'd0) ? '0 : acc_q + 66'(prod_q);
    end
    if (state_q == S_COPY) begin
      out_q.out_index <= 4'd0;
      out_q.out_value <= res_q[0];
      out_q.last      <= 1'b0;
    end else if (state_q == S_OUT && out_valid_q && !out_stall_i && e_q != 4'd15) begin
      out_q.out_index <= e_q + 1'b1;
      out_q.out_value <= work_q[e_q + 1'b1];
      out_q.last      <= (e_q == 4'd14);
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
